>>> hdl/stdc_pkg.sv
// shared types and constants for the scaled time-of-day clock
// no dependencies; imported by every module of the block
package stdc_pkg;

    localparam int MS_W      = 24;          // width of the ms_per_minute register
    localparam int REM_W     = MS_W + 1;    // partial remainder of the shared unit
    localparam int CFG_IDX_W = 2;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 16;
    localparam int ARG_W     = 8;
    localparam int UNTIL_W   = 14;

    localparam int MIN_PER_HOUR  = 60;
    localparam int HOURS_PER_DAY = 24;
    localparam int MIN_PER_DAY   = HOURS_PER_DAY * MIN_PER_HOUR;
    localparam int SKIP_MINUTES  = 8;
    localparam int RESET_HOUR    = 12;
    localparam int MS_RESET      = 1000;

    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_SET     = 2'd1,
        OP_STORE   = 2'd2,
        OP_RESTORE = 2'd3
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_MINUTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_MODE   = 2'd2;

    typedef enum logic {
        ALU_HOLD  = 1'b0,   // compare and subtract the remainder as it is
        ALU_SHIFT = 1'b1    // shift in one dividend bit first (division step)
    } t_alu_mode;

    typedef struct packed {
        t_alu_mode        mode;
        logic [REM_W-1:0] rem;
        logic             bit_in;
        logic [MS_W-1:0]  divisor;
    } t_alu_req;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic             q;
    } t_alu_rsp;

endpackage

>>> hdl/stdc_alu.sv
// shared compare-and-subtract unit: one restoring division step or one modulo step
// depends on stdc_pkg
module stdc_alu (
    input  stdc_pkg::t_alu_req i_req,
    output stdc_pkg::t_alu_rsp o_rsp
);
    import stdc_pkg::*;

    logic [REM_W-1:0] w_trial;
    logic [REM_W-1:0] w_div;

    assign w_trial = (i_req.mode == ALU_SHIFT) ? {i_req.rem[REM_W-2:0], i_req.bit_in}
                                               : i_req.rem;
    assign w_div   = {1'b0, i_req.divisor};

    always_comb begin
        if (w_trial >= w_div) begin
            o_rsp.rem = w_trial - w_div;
            o_rsp.q   = 1'b1;
        end else begin
            o_rsp.rem = w_trial;
            o_rsp.q   = 1'b0;
        end
    end

endmodule

>>> hdl/stdc_query.sv
// minutes-until and hour-range queries on the clock after an item
// depends on stdc_pkg
module stdc_query (
    input  logic [stdc_pkg::HOUR_W-1:0]   i_hour,
    input  logic [stdc_pkg::MINUTE_W-1:0] i_minute,
    input  logic [stdc_pkg::ARG_W-1:0]    i_arg_hour,
    input  logic [stdc_pkg::ARG_W-1:0]    i_arg_minute,
    input  logic [stdc_pkg::HOUR_W-1:0]   i_range_start,
    input  logic [stdc_pkg::HOUR_W-1:0]   i_range_end,
    output logic [stdc_pkg::UNTIL_W-1:0]  o_minutes_until,
    output logic                          o_in_range
);
    import stdc_pkg::*;

    logic [UNTIL_W-1:0] w_cur;
    logic [UNTIL_W-1:0] w_tgt;
    logic [UNTIL_W-1:0] w_tgt_adj;

    // times 60 as times 64 minus times 4
    assign w_cur = {3'b0, i_hour, 6'b0} - {7'b0, i_hour, 2'b0} + {8'b0, i_minute};
    assign w_tgt = {i_arg_hour, 6'b0} - {4'b0, i_arg_hour, 2'b0} + {6'b0, i_arg_minute};

    // target earlier today means tomorrow
    assign w_tgt_adj = (w_tgt < w_cur) ? w_tgt + UNTIL_W'(MIN_PER_DAY) : w_tgt;
    assign o_minutes_until = w_tgt_adj - w_cur;

    always_comb begin
        if (i_range_start > i_range_end) begin
            o_in_range = (i_hour >= i_range_start) || (i_hour < i_range_end);
        end else begin
            o_in_range = (i_hour >= i_range_start) && (i_hour < i_range_end);
        end
    end

endmodule

>>> hdl/scaled_time_of_day_clock.sv
// top level of the scaled time-of-day clock: sequencer, clock state, output register
// depends on stdc_pkg, stdc_alu, stdc_query
//
// usage:
//   input channel: i_in_valid / o_in_stall with the opcode, timestamp and query fields;
//   a word is taken at a clock edge with i_in_valid high and o_in_stall low.
//   output channel: o_out_valid / i_out_stall, one result word per input word.
//   config port: i_cfg_we, i_cfg_index, i_cfg_data; write only while idle.
// sequence per opcode:
//   update   clock advance, then the restoring division over the timestamp width
//            when ms_per_minute is zero the division is skipped
//   set      modulo 60 and modulo 24 by repeated subtraction
//   store / restore  snapshot copy, no arithmetic
// throughput: one word at a time; the block takes the next word the cycle after the
//   result goes into the output register. the restoring division, one quotient bit
//   per cycle through the shared compare-subtract unit, runs only for an update.
// stall: a finished result waits in the output register; the sequencer holds its
//   last step until that register is free, so nothing is lost or doubled.
// reset: synchronous active low; clock returns to 12:00:00, day count and snapshot
//   clear, ms_per_minute to 1000, fast and freeze modes off.
module scaled_time_of_day_clock #(
    parameter int TIMESTAMP_WIDTH = 32,
    parameter int DAY_COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config port
    input  logic                              i_cfg_we,
    input  logic [stdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stdc_pkg::MS_W-1:0]         i_cfg_data,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_opcode,
    input  logic [TIMESTAMP_WIDTH-1:0]        i_now_ms,
    input  logic                              i_skip_pressed,
    input  logic [stdc_pkg::ARG_W-1:0]        i_arg_hour,
    input  logic [stdc_pkg::ARG_W-1:0]        i_arg_minute,
    input  logic [stdc_pkg::HOUR_W-1:0]       i_range_start_hour,
    input  logic [stdc_pkg::HOUR_W-1:0]       i_range_end_hour,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [stdc_pkg::HOUR_W-1:0]       o_hour_now,
    output logic [stdc_pkg::MINUTE_W-1:0]     o_minute_now,
    output logic [stdc_pkg::SECOND_W-1:0]     o_second_now,
    output logic [DAY_COUNT_WIDTH-1:0]        o_days_elapsed,
    output logic [stdc_pkg::UNTIL_W-1:0]      o_minutes_until,
    output logic                              o_hour_in_range,
    output logic                              o_snapshot_valid
);
    import stdc_pkg::*;

    localparam int TW    = TIMESTAMP_WIDTH;
    localparam int EW    = TW + MS_W;           // wide enough to compare and add ms
    localparam int CNT_W = $clog2(TW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PREP,
        S_DIV,
        S_MOD60,
        S_MOD24,
        S_DONE
    } t_state;

    t_state r_state;

    // config registers
    logic [MS_W-1:0] r_ms;
    logic            r_fast;
    logic            r_freeze;

    // latched input word
    t_opcode             r_op;
    logic [TW-1:0]       r_now;
    logic                r_skip;
    logic [ARG_W-1:0]    r_arg_hour;
    logic [ARG_W-1:0]    r_arg_minute;
    logic [HOUR_W-1:0]   r_rs;
    logic [HOUR_W-1:0]   r_re;

    // clock state
    logic [HOUR_W-1:0]          r_hour;
    logic [MINUTE_W-1:0]        r_minute;
    logic [SECOND_W-1:0]        r_second;
    logic [TW-1:0]              r_last_tick;
    logic [DAY_COUNT_WIDTH-1:0] r_day;
    logic [HOUR_W-1:0]          r_saved_hour;
    logic [MINUTE_W-1:0]        r_saved_minute;
    logic [SECOND_W-1:0]        r_saved_second;
    logic                       r_saved_flag;

    // sequencer working registers
    logic [REM_W-1:0] r_rem;
    logic [TW-1:0]    r_dividend;
    logic [CNT_W-1:0] r_cnt;
    logic [2:0]       r_quo;

    // output register
    logic                       r_out_valid;
    logic [HOUR_W-1:0]          r_out_hour;
    logic [MINUTE_W-1:0]        r_out_minute;
    logic [SECOND_W-1:0]        r_out_second;
    logic [DAY_COUNT_WIDTH-1:0] r_out_day;
    logic [UNTIL_W-1:0]         r_out_until;
    logic                       r_out_in_range;
    logic                       r_out_saved;

    // update step next values
    logic [HOUR_W-1:0]          n_hour;
    logic [MINUTE_W-1:0]        n_minute;
    logic [TW-1:0]              n_last_tick;
    logic [DAY_COUNT_WIDTH-1:0] n_day;

    logic [TW-1:0]     w_elapsed_old;
    logic [TW-1:0]     w_elapsed_new;
    logic [EW-1:0]     w_tick_sum;
    logic [MINUTE_W:0] w_min_skip;
    logic [MINUTE_W:0] w_min_inc;
    logic [HOUR_W-1:0] w_hour_inc;
    logic              w_out_free;
    logic              w_in_accept;

    t_alu_req w_alu_req;
    t_alu_rsp w_alu_rsp;

    logic [UNTIL_W-1:0] w_until;
    logic               w_in_range;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_elapsed_old = r_now - r_last_tick;
    assign w_elapsed_new = r_now - r_last_tick;   // read in S_PREP, after the update
    assign w_tick_sum    = {{MS_W{1'b0}}, r_last_tick} + {{TW{1'b0}}, r_ms};
    assign w_min_skip    = {1'b0, r_minute} + (MINUTE_W + 1)'(SKIP_MINUTES);
    assign w_min_inc     = {1'b0, r_minute} + 1'b1;
    // hour is always below 24 here, so a single compare wraps it
    assign w_hour_inc    = (r_hour == HOUR_W'(HOURS_PER_DAY - 1)) ? '0 : r_hour + 1'b1;

    // update opcode: skip over freeze over normal advance
    always_comb begin
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_last_tick = r_last_tick;
        n_day       = r_day;
        if (r_skip) begin
            n_last_tick = r_now;
            if (w_min_skip >= (MINUTE_W + 1)'(MIN_PER_HOUR)) begin
                n_minute = '0;
                n_hour   = w_hour_inc;   // no day counted on a skip
            end else begin
                n_minute = w_min_skip[MINUTE_W-1:0];
            end
        end else if (r_freeze) begin
            n_last_tick = r_now;
        end else if (({{MS_W{1'b0}}, w_elapsed_old} > {{TW{1'b0}}, r_ms}) || r_fast) begin
            n_last_tick = r_fast ? r_now : w_tick_sum[TW-1:0];
            if (w_min_inc >= (MINUTE_W + 1)'(MIN_PER_HOUR)) begin
                n_minute = '0;
                n_hour   = w_hour_inc;
                if (r_hour == HOUR_W'(HOURS_PER_DAY - 1)) begin
                    n_day = r_day + 1'b1;
                end
            end else begin
                n_minute = w_min_inc[MINUTE_W-1:0];
            end
        end
    end

    // operand select for the shared unit
    always_comb begin
        w_alu_req.mode    = ALU_HOLD;
        w_alu_req.rem     = r_rem;
        w_alu_req.bit_in  = r_dividend[TW-1];
        w_alu_req.divisor = r_ms;
        case (r_state)
            S_DIV:   w_alu_req.mode    = ALU_SHIFT;
            S_MOD60: w_alu_req.divisor = MS_W'(MIN_PER_HOUR);
            S_MOD24: w_alu_req.divisor = MS_W'(HOURS_PER_DAY);
            default: w_alu_req.mode    = ALU_HOLD;
        endcase
    end

    stdc_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    stdc_query u_query (
        .i_hour          (r_hour),
        .i_minute        (r_minute),
        .i_arg_hour      (r_arg_hour),
        .i_arg_minute    (r_arg_minute),
        .i_range_start   (r_rs),
        .i_range_end     (r_re),
        .o_minutes_until (w_until),
        .o_in_range      (w_in_range)
    );

    // config writes, taken at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms     <= MS_W'(MS_RESET);
            r_fast   <= 1'b0;
            r_freeze <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MS_PER_MINUTE: r_ms     <= i_cfg_data;
                CFG_FAST_MODE:     r_fast   <= i_cfg_data[0];
                CFG_FREEZE_MODE:   r_freeze <= i_cfg_data[0];
                default:           r_ms     <= r_ms;
            endcase
        end
    end

    // latched input word, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op         <= t_opcode'(i_opcode);
            r_now        <= i_now_ms;
            r_skip       <= i_skip_pressed;
            r_arg_hour   <= i_arg_hour;
            r_arg_minute <= i_arg_minute;
            r_rs         <= i_range_start_hour;
            r_re         <= i_range_end_hour;
        end
    end

    // sequencer, clock state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_hour         <= HOUR_W'(RESET_HOUR);
            r_minute       <= '0;
            r_second       <= '0;
            r_last_tick    <= '0;
            r_day          <= '0;
            r_saved_hour   <= '0;
            r_saved_minute <= '0;
            r_saved_second <= '0;
            r_saved_flag   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // drained word clears valid unless a new word is loaded this cycle
            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_op)
                        OP_UPDATE: begin
                            r_hour      <= n_hour;
                            r_minute    <= n_minute;
                            r_last_tick <= n_last_tick;
                            r_day       <= n_day;
                            r_state     <= S_PREP;
                        end
                        OP_SET: begin
                            r_rem       <= {{(REM_W - ARG_W){1'b0}}, r_arg_minute};
                            r_quo       <= '0;
                            r_second    <= '0;
                            r_last_tick <= r_now;
                            r_state     <= S_MOD60;
                        end
                        OP_STORE: begin
                            r_saved_hour   <= r_hour;
                            r_saved_minute <= r_minute;
                            r_saved_second <= r_second;
                            r_saved_flag   <= 1'b1;
                            r_state        <= S_DONE;
                        end
                        OP_RESTORE: begin
                            r_hour   <= r_saved_hour;
                            r_minute <= r_saved_minute;
                            r_second <= r_saved_second;
                            r_state  <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_PREP: begin
                    // 60 * elapsed as 64x minus 4x, modulo the timestamp width
                    r_dividend <= {w_elapsed_new[TW-7:0], 6'b0}
                                - {w_elapsed_new[TW-3:0], 2'b0};
                    r_rem      <= '0;
                    r_cnt      <= CNT_W'(TW);
                    if (r_ms == '0) begin
                        r_second <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit a cycle; only the low bits of the quotient are kept
                    r_rem      <= w_alu_rsp.rem;
                    r_dividend <= {r_dividend[TW-2:0], 1'b0};
                    r_second   <= {r_second[SECOND_W-2:0], w_alu_rsp.q};
                    r_cnt      <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_MOD60: begin
                    if (w_alu_rsp.q) begin
                        r_rem <= w_alu_rsp.rem;
                        r_quo <= r_quo + 1'b1;
                    end else begin
                        // minute settled, hour = (arg_hour + carry) modulo 256, then mod 24
                        r_minute <= r_rem[MINUTE_W-1:0];
                        r_rem    <= {{(REM_W - ARG_W){1'b0}},
                                     r_arg_hour + {{(ARG_W - 3){1'b0}}, r_quo}};
                        r_state  <= S_MOD24;
                    end
                end
                S_MOD24: begin
                    if (w_alu_rsp.q) begin
                        r_rem <= w_alu_rsp.rem;
                    end else begin
                        r_hour  <= r_rem[HOUR_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // output payload, loaded as the word leaves the sequencer
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_hour     <= r_hour;
                        r_out_minute   <= r_minute;
                        r_out_second   <= r_second;
                        r_out_day      <= r_day;
                        r_out_until    <= w_until;
                        r_out_in_range <= w_in_range;
                        r_out_saved    <= r_saved_flag;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hour_now       = r_out_hour;
    assign o_minute_now     = r_out_minute;
    assign o_second_now     = r_out_second;
    assign o_days_elapsed   = r_out_day;
    assign o_minutes_until  = r_out_until;
    assign o_hour_in_range  = r_out_in_range;
    assign o_snapshot_valid = r_out_saved;

`ifndef SYNTHESIS
    // a taken word keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("input taken but block not busy");

    // a result word always carries a legal time of day
    a_legal_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hour_now < HOUR_W'(HOURS_PER_DAY))
                     && (o_minute_now < MINUTE_W'(MIN_PER_HOUR)))
        else $error("result time out of range");

    // the division never runs on a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_ms != '0))
        else $error("division with zero ms_per_minute");

    // a finished word reaches the output and the input reopens together
    a_done_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_out_valid && !o_in_stall))
        else $error("finished word not handed to the output");
`endif

endmodule
